### hdl/scpr_pkg.sv
// Package: sizes, cell interface structs and controller states for the page replacer.
`default_nettype none
package scpr_pkg;
	localparam int SLOTS      = 16;
	localparam int PAGE_WIDTH = 16;
	localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W      = $clog2(SLOTS + 1);
	localparam int CFG_W      = 5;
	localparam int PAGE_IN_W  = 16;
	localparam int SLOT_OUT_W = 4;
	localparam int COUNT_W    = 32;

	localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

	typedef logic [PAGE_WIDTH-1:0] page_t;

	// found-so-far flags rippling from slot 0 upward
	typedef struct packed {
		logic hit;
		logic hi;
		logic all;
	} chain_t;

	typedef struct packed {
		logic active;
		logic upper;
	} cell_ctl_t;

	typedef struct packed {
		logic load;
		logic set_ref;
		logic clr_ref;
	} cell_wr_t;

	typedef struct packed {
		logic valid;
		logic hit_sel;
		logic hi_sel;
		logic all_sel;
	} cell_stat_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MATCH,
		ST_UPDATE
	} state_t;
endpackage
`default_nettype wire

### hdl/second_chance_page_replacer.sv
// Top level: clock page replacer built from a row of slot cells and a small controller.
// Result: done pulses for one cycle; a reference passes the match state, the update state
//   and the result registers before done. Per reference: a match/search state over the
//   cell row, then an update state writing the cells; start is taken again during update.
// Reset: all slots empty, hand at slot 0, fault count 0, active slot count 16.
// The receiver cannot stall; done marks each result beat for one cycle only.
`default_nettype none
module second_chance_page_replacer (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [scpr_pkg::PAGE_IN_W-1:0]    page,
	input  logic                              cfg_we,
	input  logic [scpr_pkg::CFG_W-1:0]        cfg_data,
	output logic                              done,
	output logic                              fault,
	output logic [scpr_pkg::SLOT_OUT_W-1:0]   slot,
	output logic [scpr_pkg::PAGE_IN_W-1:0]    page_out,
	output logic [scpr_pkg::COUNT_W-1:0]      fault_total
);
	import scpr_pkg::*;

	state_t                 state_q;
	state_t                 state_d;
	logic                   accept;
	logic                   upd;
	logic [CFG_W-1:0]       cfg_q;
	logic [SLOT_W-1:0]      hand_q;
	logic [COUNT_W-1:0]     fault_cnt_q;
	logic [CNT_W-1:0]       n;
	logic [SLOT_W-1:0]      pos;
	page_t                  page_s1;

	chain_t                 chain_in  [SLOTS];
	chain_t                 chain_out [SLOTS];
	cell_stat_t             stat      [SLOTS];
	cell_ctl_t              ctl       [SLOTS];
	cell_wr_t               wr        [SLOTS];
	logic [SLOTS-1:0]       hit_vec;
	logic [SLOTS-1:0]       hi_vec;
	logic [SLOTS-1:0]       all_vec;
	logic [SLOTS-1:0]       valid_vec;
	logic [SLOT_W-1:0]      hit_idx;
	logic [SLOT_W-1:0]      hi_idx;
	logic [SLOT_W-1:0]      all_idx;
	logic [SLOT_W-1:0]      vic_d;
	logic                   any_hi;
	logic                   any_all;

	logic                   hit_s2;
	logic [SLOT_W-1:0]      hit_idx_s2;
	logic [SLOT_W-1:0]      vic_s2;
	logic [SLOT_W-1:0]      pos_s2;
	logic                   nocand_s2;
	logic [CNT_W-1:0]       hand_nxt;

	logic                   done_q;
	logic                   fault_q;
	logic [SLOT_OUT_W-1:0]  slot_q;
	logic [PAGE_IN_W-1:0]   page_out_q;
	logic [COUNT_W-1:0]     total_q;

	// controller
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (start) state_d = ST_MATCH;
			ST_MATCH:  state_d = ST_UPDATE;
			ST_UPDATE: state_d = start ? ST_MATCH : ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		busy   = (state_q == ST_MATCH);
		upd    = (state_q == ST_UPDATE);
		accept = start & ~busy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			cfg_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			page_s1 <= PAGE_WIDTH'(page);
		end
	end

	// active slot count and sweep start
	always_comb begin
		if (32'(cfg_q) > SLOTS) begin
			n = CNT_W'(SLOTS);
		end else if (cfg_q == '0) begin
			n = CNT_W'(1);
		end else begin
			n = CNT_W'(cfg_q);
		end
		pos = (CNT_W'(hand_q) >= n) ? '0 : hand_q;
	end

	// cell row
	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		if (i == 0) begin : g_head
			assign chain_in[i] = '0;
		end else begin : g_link
			assign chain_in[i] = chain_out[i-1];
		end

		assign ctl[i].active = (CNT_W'(i) < n);
		assign ctl[i].upper  = (SLOT_W'(i) >= pos);

		assign wr[i].load    = upd & ~hit_s2 & (SLOT_W'(i) == vic_s2);
		assign wr[i].set_ref = upd & hit_s2 & (SLOT_W'(i) == hit_idx_s2);
		// slots passed over by the hand lose their second chance
		assign wr[i].clr_ref = upd & ~hit_s2 & ctl[i].active &
			(nocand_s2 |
			 ((vic_s2 >= pos_s2) ?
				((SLOT_W'(i) >= pos_s2) && (SLOT_W'(i) < vic_s2)) :
				((SLOT_W'(i) >= pos_s2) || (SLOT_W'(i) < vic_s2))));

		assign hit_vec[i]   = stat[i].hit_sel;
		assign hi_vec[i]    = stat[i].hi_sel;
		assign all_vec[i]   = stat[i].all_sel;
		assign valid_vec[i] = stat[i].valid;

		scpr_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmp_page  (page_s1),
			.ctl       (ctl[i]),
			.chain_in  (chain_in[i]),
			.chain_out (chain_out[i]),
			.stat      (stat[i]),
			.wr        (wr[i]),
			.wr_page   (page_s1)
		);
	end

	// one-hot selects to slot numbers
	always_comb begin
		hit_idx = '0;
		hi_idx  = '0;
		all_idx = '0;
		for (int j = 0; j < SLOTS; j++) begin
			if (hit_vec[j]) hit_idx = hit_idx | SLOT_W'(j);
			if (hi_vec[j])  hi_idx  = hi_idx  | SLOT_W'(j);
			if (all_vec[j]) all_idx = all_idx | SLOT_W'(j);
		end
	end

	assign any_hi  = chain_out[SLOTS-1].hi;
	assign any_all = chain_out[SLOTS-1].all;
	// no candidate at or past the hand: wrap to the lowest; none at all: hand's own slot
	assign vic_d   = any_hi ? hi_idx : (any_all ? all_idx : pos);

	always_ff @(posedge clk) begin
		if (busy) begin
			hit_s2     <= chain_out[SLOTS-1].hit;
			hit_idx_s2 <= hit_idx;
			vic_s2     <= vic_d;
			pos_s2     <= pos;
			nocand_s2  <= ~any_all;
		end
	end

	assign hand_nxt = CNT_W'(vic_s2) + CNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hand_q      <= '0;
			fault_cnt_q <= '0;
		end else if (upd && !hit_s2) begin
			hand_q      <= (hand_nxt == n) ? '0 : SLOT_W'(hand_nxt);
			fault_cnt_q <= fault_cnt_q + COUNT_W'(1);
		end
	end

	// result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= upd;
		end
	end

	always_ff @(posedge clk) begin
		if (upd) begin
			fault_q    <= ~hit_s2;
			slot_q     <= SLOT_OUT_W'(hit_s2 ? hit_idx_s2 : vic_s2);
			page_out_q <= PAGE_IN_W'(page_s1);
			total_q    <= hit_s2 ? fault_cnt_q : (fault_cnt_q + COUNT_W'(1));
		end
	end

	assign done        = done_q;
	assign fault       = fault_q;
	assign slot        = slot_q;
	assign page_out    = page_out_q;
	assign fault_total = total_q;

	a_match_then_update: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MATCH) |=> (state_q == ST_UPDATE))
		else $error("match cycle not followed by update");

	a_single_selects: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> ($onehot0(hit_vec) && $onehot0(hi_vec) && $onehot0(all_vec)))
		else $error("more than one slot selected");

	a_hit_is_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(upd && hit_s2) |-> valid_vec[hit_idx_s2])
		else $error("hit on an empty slot");

	a_fault_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(upd && !hit_s2) |=> (fault_cnt_q == $past(fault_cnt_q) + COUNT_W'(1)))
		else $error("fault count did not advance on a miss");

	a_done_after_update: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(upd))
		else $error("result beat without an update cycle");
endmodule
`default_nettype wire

### hdl/scpr_cell.sv
// One page slot: stored page, valid and reference bits, plus its link in the search chain.
`default_nettype none
module scpr_cell (
	input  logic                   clk,
	input  logic                   arst_n,
	input  scpr_pkg::page_t        cmp_page,
	input  scpr_pkg::cell_ctl_t    ctl,
	input  scpr_pkg::chain_t       chain_in,
	output scpr_pkg::chain_t       chain_out,
	output scpr_pkg::cell_stat_t   stat,
	input  scpr_pkg::cell_wr_t     wr,
	input  scpr_pkg::page_t        wr_page
);
	import scpr_pkg::*;

	page_t page_q;
	logic  valid_q;
	logic  ref_q;
	logic  match;
	logic  cand;
	logic  cand_hi;

	assign match   = ctl.active & valid_q & (page_q == cmp_page);
	// replacement candidate: empty or second chance used up
	assign cand    = ctl.active & (~valid_q | ~ref_q);
	assign cand_hi = cand & ctl.upper;

	assign chain_out.hit = chain_in.hit | match;
	assign chain_out.hi  = chain_in.hi  | cand_hi;
	assign chain_out.all = chain_in.all | cand;

	assign stat.valid   = valid_q;
	assign stat.hit_sel = match   & ~chain_in.hit;
	assign stat.hi_sel  = cand_hi & ~chain_in.hi;
	assign stat.all_sel = cand    & ~chain_in.all;

	always_ff @(posedge clk) begin
		if (wr.load) begin
			page_q <= wr_page;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			ref_q   <= 1'b0;
		end else if (wr.load) begin
			valid_q <= 1'b1;
			ref_q   <= 1'b0;
		end else if (wr.set_ref) begin
			ref_q <= 1'b1;
		end else if (wr.clr_ref) begin
			ref_q <= 1'b0;
		end
	end
endmodule
`default_nettype wire
